>>> sv/arw_pkg.sv
// Package with the request, response and control types shared by the watch table modules.
package arw_pkg;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic WATCH_SIDE_WRITE = 1'b0;
    localparam logic WATCH_SIDE_READ  = 1'b1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_WATCH_ENABLE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_WATCH_ENABLE  = 4'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic        watch_side;
        logic [31:0] access_address;
        logic [3:0]  access_bytes;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } req_t;

    typedef struct packed {
        logic       watch_hit;
        logic       status;
        logic [5:0] ranges_in_use;
    } rsp_t;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_ADD,
        TBL_REMOVE,
        TBL_CLEAR
    } tbl_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       occupied;
    } cell_ctl_t;

endpackage

>>> sv/arw_cell.sv
// One slot of a range table: holds a range, compares it with the current request and shifts.
module arw_cell #(
    parameter int ADDR_BITS = 29
) (
    input  logic                  clk,
    input  arw_pkg::cell_ctl_t    ctl,
    input  logic [ADDR_BITS-1:0]  prev_lo,
    input  logic [ADDR_BITS-1:0]  prev_hi,
    input  logic [ADDR_BITS-1:0]  next_lo,
    input  logic [ADDR_BITS-1:0]  next_hi,
    input  logic [ADDR_BITS-1:0]  key_lo,
    input  logic [ADDR_BITS-1:0]  key_hi,
    input  logic [ADDR_BITS-1:0]  span_start,
    input  logic [ADDR_BITS:0]    span_end,
    output logic [ADDR_BITS-1:0]  lo,
    output logic [ADDR_BITS-1:0]  hi,
    output logic                  hit,
    output logic                  match
);
    import arw_pkg::*;

    logic [ADDR_BITS-1:0] lo_reg;
    logic [ADDR_BITS-1:0] lo_next;
    logic [ADDR_BITS-1:0] hi_reg;
    logic [ADDR_BITS-1:0] hi_next;

    always_comb
    begin
        case (ctl.mode)
            CELL_TAKE_PREV:
            begin
                lo_next = prev_lo;
                hi_next = prev_hi;
            end
            CELL_TAKE_NEXT:
            begin
                lo_next = next_lo;
                hi_next = next_hi;
            end
            default:
            begin
                lo_next = lo_reg;
                hi_next = hi_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo    = lo_reg;
    assign hi    = hi_reg;
    assign hit   = ctl.occupied && (span_start <= hi_reg) && (span_end >= {1'b0, lo_reg});
    assign match = ctl.occupied && (lo_reg == key_lo) && (hi_reg == key_hi);

endmodule

>>> sv/arw_table.sv
// One range table: a row of slot cells with its fill count and shift control.
module arw_table #(
    parameter int SLOTS     = 32,
    parameter int ADDR_BITS = 29
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arw_pkg::tbl_op_t              op,
    input  logic [ADDR_BITS-1:0]          new_lo,
    input  logic [ADDR_BITS-1:0]          new_hi,
    input  logic [ADDR_BITS-1:0]          key_lo,
    input  logic [ADDR_BITS-1:0]          key_hi,
    input  logic [ADDR_BITS-1:0]          span_start,
    input  logic [ADDR_BITS:0]            span_end,
    output logic                          any_hit,
    output logic                          full,
    output logic [$clog2(SLOTS+1)-1:0]    count,
    output logic [$clog2(SLOTS+1)-1:0]    count_after
);
    import arw_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [ADDR_BITS-1:0] lo_q [SLOTS];
    logic [ADDR_BITS-1:0] hi_q [SLOTS];
    logic [SLOTS-1:0]     hit_v;
    logic [SLOTS-1:0]     match_v;
    logic [SLOTS-1:0]     seen_v;
    logic                 any_match;

    assign full      = (count_reg == CNT_W'(SLOTS));
    assign any_match = seen_v[SLOTS-1];
    assign any_hit   = |hit_v;

    genvar j;
    generate
        for (j = 0; j < SLOTS; j++)
        begin : g_cell
            cell_ctl_t            ctl;
            logic [ADDR_BITS-1:0] p_lo;
            logic [ADDR_BITS-1:0] p_hi;
            logic [ADDR_BITS-1:0] n_lo;
            logic [ADDR_BITS-1:0] n_hi;

            if (j == 0)
            begin : g_first
                assign seen_v[j] = match_v[j];
                assign p_lo      = new_lo;
                assign p_hi      = new_hi;
            end
            else
            begin : g_rest
                assign seen_v[j] = seen_v[j-1] | match_v[j];
                assign p_lo      = lo_q[j-1];
                assign p_hi      = hi_q[j-1];
            end

            if (j == SLOTS - 1)
            begin : g_last
                assign n_lo = lo_q[j];
                assign n_hi = hi_q[j];
            end
            else
            begin : g_inner
                assign n_lo = lo_q[j+1];
                assign n_hi = hi_q[j+1];
            end

            always_comb
            begin
                ctl.occupied = (CNT_W'(j) < count_reg);
                case (op)
                    TBL_ADD:    ctl.mode = full ? CELL_HOLD : CELL_TAKE_PREV;
                    TBL_REMOVE: ctl.mode = seen_v[j] ? CELL_TAKE_NEXT : CELL_HOLD;
                    default:    ctl.mode = CELL_HOLD;
                endcase
            end

            arw_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .prev_lo    (p_lo),
                .prev_hi    (p_hi),
                .next_lo    (n_lo),
                .next_hi    (n_hi),
                .key_lo     (key_lo),
                .key_hi     (key_hi),
                .span_start (span_start),
                .span_end   (span_end),
                .lo         (lo_q[j]),
                .hi         (hi_q[j]),
                .hit        (hit_v[j]),
                .match      (match_v[j])
            );
        end
    endgenerate

    always_comb
    begin
        case (op)
            TBL_ADD:    count_next = full ? count_reg : count_reg + CNT_W'(1);
            TBL_REMOVE: count_next = any_match ? count_reg - CNT_W'(1) : count_reg;
            TBL_CLEAR:  count_next = '0;
            default:    count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count       = count_reg;
    assign count_after = count_next;

endmodule

>>> sv/address_range_watch_table.sv
// Top level of the address range watch table: request decode, two range tables, response register.
//
//   Channel | Signals                          | Direction | Contents
//   --------+----------------------------------+-----------+---------------------------------
//   req     | req_valid, req_ready, req        | in        | command, side, access, range
//   rsp     | rsp_valid, rsp_ready, rsp        | out       | hit, status, ranges in use
//   cfg     | cfg_valid, cfg_ready, cfg_index, | in        | watch enables for each side
//           | cfg_data                         |           |
//
// One request is accepted per cycle; its response is registered and offered in the next cycle.
// Every slot cell compares, and shifts where the command calls for it, in the cycle of acceptance,
// so the next request sees the updated table. A stalled response holds the request channel only
// until it is taken. Reset clears both fill counts and both enables; slot contents need no reset.
module address_range_watch_table #(
    parameter int RANGE_SLOTS    = 32,
    parameter int PHYS_ADDR_BITS = 29
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  arw_pkg::req_t                         req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output arw_pkg::rsp_t                         rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arw_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [arw_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import arw_pkg::*;

    localparam int AB    = PHYS_ADDR_BITS;
    localparam int CNT_W = $clog2(RANGE_SLOTS + 1);

    logic             accept;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             wen_reg;
    logic             wen_next;
    logic             ren_reg;
    logic             ren_next;

    logic [AB-1:0]    addr_m;
    logic [AB-1:0]    lo_m;
    logic [AB-1:0]    hi_m;
    logic [AB-1:0]    new_lo;
    logic [AB-1:0]    new_hi;
    logic [3:0]       bytes_eff;
    logic [AB:0]      span_end;
    tbl_op_t          op_any;
    tbl_op_t          wr_op;
    tbl_op_t          rd_op;

    logic             wr_hit;
    logic             wr_full;
    logic [CNT_W-1:0] wr_count;
    logic [CNT_W-1:0] wr_after;
    logic             rd_hit;
    logic             rd_full;
    logic [CNT_W-1:0] rd_count;
    logic [CNT_W-1:0] rd_after;

    logic             sel_hit;
    logic             sel_full;
    logic             sel_en;
    logic [CNT_W+5:0] sel_after_wide;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign addr_m    = req.access_address[AB-1:0];
    assign lo_m      = req.range_low[AB-1:0];
    assign hi_m      = req.range_high[AB-1:0];
    assign new_lo    = (hi_m < lo_m) ? hi_m : lo_m;
    assign new_hi    = (hi_m < lo_m) ? lo_m : hi_m;
    assign bytes_eff = (req.access_bytes == 4'd0) ? 4'd1 : req.access_bytes;
    assign span_end  = {1'b0, addr_m} + (AB+1)'(bytes_eff) - (AB+1)'(1);

    always_comb
    begin
        case (req.command)
            CMD_ADD:    op_any = TBL_ADD;
            CMD_REMOVE: op_any = TBL_REMOVE;
            CMD_CLEAR:  op_any = TBL_CLEAR;
            default:    op_any = TBL_NONE;
        endcase
    end

    assign wr_op = (accept && req.watch_side == WATCH_SIDE_WRITE) ? op_any : TBL_NONE;
    assign rd_op = (accept && req.watch_side == WATCH_SIDE_READ) ? op_any : TBL_NONE;

    arw_table #(
        .SLOTS     (RANGE_SLOTS),
        .ADDR_BITS (AB)
    ) u_write_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (wr_op),
        .new_lo      (new_lo),
        .new_hi      (new_hi),
        .key_lo      (lo_m),
        .key_hi      (hi_m),
        .span_start  (addr_m),
        .span_end    (span_end),
        .any_hit     (wr_hit),
        .full        (wr_full),
        .count       (wr_count),
        .count_after (wr_after)
    );

    arw_table #(
        .SLOTS     (RANGE_SLOTS),
        .ADDR_BITS (AB)
    ) u_read_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (rd_op),
        .new_lo      (new_lo),
        .new_hi      (new_hi),
        .key_lo      (lo_m),
        .key_hi      (hi_m),
        .span_start  (addr_m),
        .span_end    (span_end),
        .any_hit     (rd_hit),
        .full        (rd_full),
        .count       (rd_count),
        .count_after (rd_after)
    );

    assign sel_hit        = (req.watch_side == WATCH_SIDE_READ) ? rd_hit : wr_hit;
    assign sel_full       = (req.watch_side == WATCH_SIDE_READ) ? rd_full : wr_full;
    assign sel_en         = (req.watch_side == WATCH_SIDE_READ) ? ren_reg : wen_reg;
    assign sel_after_wide = {6'b0, ((req.watch_side == WATCH_SIDE_READ) ? rd_after : wr_after)};

    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg;
        if (accept)
        begin
            rsp_next.watch_hit     = (req.command == CMD_CHECK) && sel_en && sel_hit;
            rsp_next.status        = (req.command == CMD_ADD) && sel_full;
            rsp_next.ranges_in_use = sel_after_wide[5:0];
            rsp_valid_next         = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        wen_next = wen_reg;
        ren_next = ren_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_WRITE_WATCH_ENABLE)
            begin
                wen_next = cfg_data[0];
            end
            if (cfg_index == CFG_READ_WATCH_ENABLE)
            begin
                ren_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            wen_reg       <= 1'b0;
            ren_reg       <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            wen_reg       <= wen_next;
            ren_reg       <= ren_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An add on the write table with room grows that table's count by one.
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_ADD && req.watch_side == WATCH_SIDE_WRITE && !wr_full)
        |=> (wr_count == $past(wr_count) + CNT_W'(1)))
        else $error("write table count did not grow after an add");

    // A request on the write side leaves the read table's count alone.
    a_side_isolated: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.watch_side == WATCH_SIDE_WRITE) |=> $stable(rd_count))
        else $error("read table count changed on a write side request");

    // A clear on the read side empties the read table and reports zero ranges in use.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_CLEAR && req.watch_side == WATCH_SIDE_READ)
        |=> (rd_count == '0 && rsp_reg.ranges_in_use == 6'd0))
        else $error("read table not empty after clear");

    // A full table refuses an add with a full status.
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_ADD && sel_full) |=> (rsp_valid && rsp_reg.status))
        else $error("add on a full table was not refused");

    // A check on a disabled side never reports a hit.
    a_disabled_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sel_en) |=> !rsp_reg.watch_hit)
        else $error("hit reported on a disabled side");

endmodule

>>> bench/address_range_watch_table_test.sv
// Self-checking testbench for the address range watch table: directed and random requests.
module address_range_watch_table_test;
    import arw_pkg::*;

    localparam int SLOTS     = 32;
    localparam int ADDR_BITS = 29;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = '1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
    } span_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b1;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    span_t spans [2][SLOTS];
    int    fill [2]     = '{0, 0};
    logic  watch_en [2] = '{1'b0, 1'b0};
    rsp_t  pending_rsp [$];
    int    errors     = 0;
    int    gap_pct    = 0;
    int    stall_pct  = 0;
    int    stall_left = 0;

    address_range_watch_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rsp_t run_watch_command(req_t r);
        rsp_t                 res;
        logic                 side;
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
        logic [ADDR_BITS-1:0] tmp;
        longint unsigned      first;
        longint unsigned      last;
        logic                 found;
        res   = '0;
        side  = r.watch_side;
        lo    = r.range_low[ADDR_BITS-1:0];
        hi    = r.range_high[ADDR_BITS-1:0];
        found = 1'b0;
        case (cmd_t'(r.command))
            CMD_CHECK:
            begin
                first = r.access_address[ADDR_BITS-1:0];
                last  = first + ((r.access_bytes == 4'd0) ? 1 : r.access_bytes) - 1;
                if (watch_en[side])
                begin
                    for (int i = 0; i < fill[side]; i++)
                    begin
                        if (first <= spans[side][i].hi && last >= spans[side][i].lo)
                            res.watch_hit = 1'b1;
                    end
                end
            end
            CMD_ADD:
            begin
                if (hi < lo)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (fill[side] >= SLOTS)
                    res.status = 1'b1;
                else
                begin
                    spans[side][fill[side]].lo = lo;
                    spans[side][fill[side]].hi = hi;
                    fill[side]++;
                end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < fill[side]; i++)
                begin
                    if (!found && spans[side][i].lo == lo && spans[side][i].hi == hi)
                    begin
                        spans[side][i] = spans[side][fill[side] - 1];
                        fill[side]--;
                        found = 1'b1;
                    end
                end
            end
            CMD_CLEAR:
                fill[side] = 0;
            default: ;
        endcase
        res.ranges_in_use = 6'(fill[side]);
        return res;
    endfunction

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WRITE_WATCH_ENABLE: watch_en[WATCH_SIDE_WRITE] = cfg_data[0];
                    CFG_READ_WATCH_ENABLE:  watch_en[WATCH_SIDE_READ]  = cfg_data[0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                pending_rsp = {pending_rsp, run_watch_command(req)};
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response expected none, got %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    compare_field("watch_hit", want.watch_hit, rsp.watch_hit);
                    compare_field("status", want.status, rsp.status);
                    compare_field("ranges_in_use", want.ranges_in_use, rsp.ranges_in_use);
                end
            end
        end
    end

    // The response side stalls in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(6, 1) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    function automatic req_t make_req(cmd_t cmd, logic side, logic [31:0] addr,
                                      logic [3:0] bytes, logic [31:0] lo, logic [31:0] hi);
        req_t r;
        r.command        = cmd;
        r.watch_side     = side;
        r.access_address = addr;
        r.access_bytes   = bytes;
        r.range_low      = lo;
        r.range_high     = hi;
        return r;
    endfunction

    function automatic logic [31:0] scramble_top(logic [31:0] v);
        return {3'($urandom_range(7)), v[ADDR_BITS-1:0]};
    endfunction

    // Valid stays high after acceptance so that a following request can go out back to back.
    task automatic send(input req_t r);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic check_at(input logic side, input logic [31:0] addr, input logic [3:0] bytes);
        send(make_req(CMD_CHECK, side, addr, bytes, $urandom, $urandom));
    endtask

    task automatic add_range(input logic side, input logic [31:0] lo, input logic [31:0] hi);
        send(make_req(CMD_ADD, side, lo, 4'($urandom_range(15)), lo, hi));
    endtask

    task automatic remove_range(input logic side, input logic [31:0] lo, input logic [31:0] hi);
        send(make_req(CMD_REMOVE, side, hi, 4'($urandom_range(15)), lo, hi));
    endtask

    task automatic clear_side(input logic side);
        send(make_req(CMD_CLEAR, side, $urandom, 4'($urandom_range(15)), $urandom, $urandom));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_watch(input logic w_on, input logic r_on);
        logic [31:0] noise;
        drain();
        noise    = $urandom;
        noise[0] = w_on;
        cfg_write(CFG_WRITE_WATCH_ENABLE, noise);
        noise    = $urandom;
        noise[0] = r_on;
        cfg_write(CFG_READ_WATCH_ENABLE, noise);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_after_reset();
        gap_pct   = 25;
        stall_pct = 25;
        check_at(WATCH_SIDE_WRITE, $urandom, 4'd8);
        check_at(WATCH_SIDE_READ, $urandom, 4'd1);
        remove_range(WATCH_SIDE_WRITE, 32'd1, 32'd2);
        add_range(WATCH_SIDE_WRITE, 32'h0000_1000, 32'h0000_10ff);
        add_range(WATCH_SIDE_READ, 32'h0000_1000, 32'h0000_10ff);
        check_at(WATCH_SIDE_WRITE, 32'h0000_1010, 4'd4);
        drain();
        cfg_write(CFG_SPARE_INDEX, $urandom);
        cfg_valid <= 1'b0;
        check_at(WATCH_SIDE_READ, 32'h0000_1010, 4'd4);
    endtask

    task automatic test_edge_cases();
        gap_pct   = 30;
        stall_pct = 20;
        clear_side(WATCH_SIDE_WRITE);
        clear_side(WATCH_SIDE_READ);
        add_range(WATCH_SIDE_WRITE, 32'he000_0200, 32'h2000_0100);
        check_at(WATCH_SIDE_WRITE, 32'h0000_00f9, 4'd8);
        check_at(WATCH_SIDE_WRITE, 32'h0000_00f8, 4'd8);
        check_at(WATCH_SIDE_WRITE, 32'h0000_0201, 4'd1);
        check_at(WATCH_SIDE_WRITE, 32'he000_0150, 4'd0);
        check_at(WATCH_SIDE_WRITE, 32'h0000_00f2, 4'd15);
        add_range(WATCH_SIDE_WRITE, 32'hffff_ffff, 32'h1fff_fff0);
        check_at(WATCH_SIDE_WRITE, 32'hffff_ffff, 4'd15);
        add_range(WATCH_SIDE_WRITE, 32'd0, 32'd0);
        check_at(WATCH_SIDE_READ, 32'h0000_0150, 4'd1);
        remove_range(WATCH_SIDE_WRITE, 32'h0000_0200, 32'h0000_0100);
        remove_range(WATCH_SIDE_WRITE, 32'h2000_0100, 32'h4000_0200);
        check_at(WATCH_SIDE_WRITE, 32'h0000_0150, 4'd2);
        check_at(WATCH_SIDE_WRITE, 32'h0000_0000, 4'd1);
        remove_range(WATCH_SIDE_WRITE, 32'd5, 32'd6);
        add_range(WATCH_SIDE_READ, 32'h0000_0000, 32'hffff_ffff);
        check_at(WATCH_SIDE_READ, 32'hffff_fff8, 4'd8);
        clear_side(WATCH_SIDE_WRITE);
        check_at(WATCH_SIDE_WRITE, 32'h0000_0000, 4'd1);
        clear_side(WATCH_SIDE_READ);
    endtask

    task automatic test_full_table();
        logic [31:0] keep_lo;
        logic [31:0] keep_hi;
        keep_lo   = 32'h0123_4567;
        keep_hi   = 32'h0123_4600;
        gap_pct   = 15;
        stall_pct = 15;
        for (int i = 0; i <= SLOTS; i++)
        begin
            if (i == 7)
                add_range(WATCH_SIDE_READ, keep_lo, keep_hi);
            else
                add_range(WATCH_SIDE_READ, $urandom, $urandom);
        end
        add_range(WATCH_SIDE_READ, keep_lo, keep_hi);
        check_at(WATCH_SIDE_READ, keep_hi, 4'd1);
        remove_range(WATCH_SIDE_READ, {3'b101, keep_lo[ADDR_BITS-1:0]}, keep_hi);
        add_range(WATCH_SIDE_READ, keep_lo, keep_hi);
        clear_side(WATCH_SIDE_READ);
    endtask

    // Requests draw their bounds from a small pool so that removes find matches and
    // checks land close to the stored bounds.
    task automatic test_traffic(input int items, input logic w_on, input logic r_on,
                                input int add_pct, input int rem_pct,
                                input int gap, input int stall);
        logic [31:0] pool_lo [8];
        logic [31:0] pool_hi [8];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [3:0]  bytes;
        logic        side;
        logic        flip;
        int          roll;
        int          k;
        set_watch(w_on, r_on);
        gap_pct   = gap;
        stall_pct = stall;
        for (int p = 0; p < 8; p++)
        begin
            pool_lo[p] = $urandom;
            pool_hi[p] = pool_lo[p] + (($urandom_range(3) == 0) ? $urandom_range(1 << 20)
                                                                 : $urandom_range(64));
        end
        for (int n = 0; n < items; n++)
        begin
            roll  = $urandom_range(99);
            side  = 1'($urandom_range(1));
            k     = $urandom_range(7);
            lo    = pool_lo[k];
            hi    = pool_hi[k];
            bytes = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                             : 4'(1 << $urandom_range(3));
            if (roll < 8)
                send(make_req(cmd_t'($urandom_range(3)), side, $urandom,
                              4'($urandom_range(15)), $urandom, $urandom));
            else if (roll < 10)
                clear_side(side);
            else if (roll < 10 + add_pct)
            begin
                flip = 1'($urandom_range(1));
                add_range(side, scramble_top(flip ? hi : lo), scramble_top(flip ? lo : hi));
            end
            else if (roll < 10 + add_pct + rem_pct)
            begin
                flip = ($urandom_range(9) == 0);
                remove_range(side, scramble_top(flip ? hi : lo), scramble_top(flip ? lo : hi));
            end
            else
            begin
                flip = 1'($urandom_range(1));
                check_at(side, scramble_top((flip ? hi : lo) + $urandom_range(18) - 9), bytes);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        set_watch(1'b1, 1'b1);
        test_edge_cases();
        test_full_table();
        test_traffic(200, 1'b1, 1'b1, 45, 25, 20, 20);
        test_traffic(150, 1'b0, 1'b0, 40, 25, 30, 10);
        test_traffic(150, 1'b1, 1'b0, 45, 20, 0, 0);
        test_traffic(150, 1'b0, 1'b1, 60, 10, 40, 40);
        test_traffic(250, 1'b1, 1'b1, 35, 30, 10, 30);
        test_traffic(200, 1'($urandom_range(1)), 1'($urandom_range(1)), 50, 20, 25, 25);
        test_traffic(250, 1'b1, 1'b1, 40, 25, 0, 0);
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
sv/arw_pkg.sv
sv/arw_cell.sv
sv/arw_table.sv
sv/address_range_watch_table.sv
bench/address_range_watch_table_test.sv
